// File: design/lru_bbct_pkg.sv
// Shared types, codes and constants of the block buffer cache tag engine.
package lru_bbct_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam logic [6:0] DIRTY_LIMIT_RST = 7'd48;
    localparam logic [6:0] DIRTY_MAX = 7'd127;
    localparam logic [15:0] REFS_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ACT_GET        = 3'd0,
        ACT_LOAD_DONE  = 3'd1,
        ACT_PUT        = 3'd2,
        ACT_MARK_DIRTY = 3'd3,
        ACT_SYNC       = 3'd4,
        ACT_WRITE_DONE = 3'd5,
        ACT_FLUSH      = 3'd6,
        ACT_STATS      = 3'd7
    } action_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_HIT          = 4'd1,
        ST_READ_REQ     = 4'd2,
        ST_WAIT_LOADING = 4'd3,
        ST_NO_SLOT      = 4'd4,
        ST_BAD_DEVICE   = 4'd5,
        ST_PUT_UNREF    = 4'd6,
        ST_SYNC_NEEDED  = 4'd7,
        ST_WRITE_REQ    = 4'd8,
        ST_SYNC_EMPTY   = 4'd9
    } status_t;

    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [15:0] refs;
        logic [63:0] stamp;
    } slot_ent_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_EV   = 6'b000100,
        S_VIC  = 6'b001000,
        S_SEND = 6'b010000,
        S_FIN  = 6'b100000
    } seq_state_t;

endpackage

// File: design/lru_block_buffer_cache_tags_top.sv
// Top level of the block buffer cache tag and policy engine.
// Flow: stats, get on device 0 and an out-of-range slot go straight to the result;
// load_done, put, mark_dirty and write_done first read their slot. get, sync and flush
// walk every slot through the one slot memory read port, reading (S_RD) then evaluating
// (S_EV) each; a hit or a wait ends a get walk early. Any time waiting on res_ready adds on.
// Throughput: one request at a time; req_ready is high only between requests.
// Reset (rst_n, asynchronous, low): all slots invalid and unwritten, counters zero,
// dirty_limit 48; no clearing pass, an unwritten slot reads as all zero.
module lru_block_buffer_cache_tags_top #(
    parameter int SLOT_COUNT = lru_bbct_pkg::SLOT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dirty_limit_we,
    input  logic [6:0]  dirty_limit_wdata,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  device,
    input  logic [31:0] block,
    input  logic [5:0]  slot,
    input  logic        io_error,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [3:0]  status,
    output logic [5:0]  result_slot,
    output logic [7:0]  result_device,
    output logic [31:0] result_block,
    output logic        last,
    output logic [31:0] hit_count,
    output logic [31:0] miss_count,
    output logic [6:0]  dirty_total
);
    import lru_bbct_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // slot tag memory: key, refcount, use stamp; one read and one write port
    slot_ent_t mem [SLOT_COUNT];
    slot_ent_t rd_q;

    // per-slot flags in flip-flops; wflag marks a memory entry holding real data
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [SLOT_COUNT-1:0] loading_reg, loading_next;
    logic [SLOT_COUNT-1:0] dirty_reg, dirty_next;
    logic [SLOT_COUNT-1:0] wflag_reg, wflag_next;
    logic rd_flag_reg;

    seq_state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // latched request
    action_t req_act_reg, req_act_next;
    logic [7:0]  req_dev_reg, req_dev_next;
    logic [31:0] req_blk_reg, req_blk_next;
    logic        req_err_reg, req_err_next;

    logic [63:0] use_clock_reg, use_clock_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic [31:0] hits_reg, hits_next;
    logic [31:0] miss_reg, miss_next;
    logic [6:0]  dlimit_reg;

    // victim search
    logic             free_vld_reg, free_vld_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [63:0]      best_stamp_reg, best_stamp_next;

    // final result of the request
    status_t     res_st_reg, res_st_next;
    logic [5:0]  res_slot_reg, res_slot_next;
    logic [7:0]  res_dev_reg, res_dev_next;
    logic [31:0] res_blk_reg, res_blk_next;

    // write request held back until it is known whether it is the last one
    logic        pend_vld_reg, pend_vld_next;
    logic [5:0]  pend_slot_reg, pend_slot_next;
    logic [7:0]  pend_dev_reg, pend_dev_next;
    logic [31:0] pend_blk_reg, pend_blk_next;

    // output register
    logic        out_vld_reg;
    status_t     out_st_reg;
    logic [5:0]  out_slot_reg;
    logic [7:0]  out_dev_reg;
    logic [31:0] out_blk_reg;
    logic        out_last_reg;
    logic [31:0] out_hits_reg, out_miss_reg;
    logic [6:0]  out_dcnt_reg;

    logic        push, push_last;
    status_t     push_st;
    logic [5:0]  push_slot;
    logic [7:0]  push_dev;
    logic [31:0] push_blk;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_ent_t        mem_wdata;
    logic             mem_re;

    slot_ent_t ent;
    logic      out_free;
    action_t   act_in;

    assign ent      = rd_flag_reg ? rd_q : '0;
    assign out_free = !out_vld_reg || res_ready;
    assign act_in   = action_t'(action);
    assign mem_re   = (state_reg == S_RD);
    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= mem[idx_reg];
        end
    end

    always_comb
    begin
        logic [15:0] refs_inc;
        logic        v, l, d, match, wmatch, blocked;
        logic [IDX_W-1:0] vic;
        logic        vic_ok;

        state_next      = state_reg;
        idx_next        = idx_reg;
        req_act_next    = req_act_reg;
        req_dev_next    = req_dev_reg;
        req_blk_next    = req_blk_reg;
        req_err_next    = req_err_reg;
        valid_next      = valid_reg;
        loading_next    = loading_reg;
        dirty_next      = dirty_reg;
        wflag_next      = wflag_reg;
        use_clock_next  = use_clock_reg;
        dcnt_next       = dcnt_reg;
        hits_next       = hits_reg;
        miss_next       = miss_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        res_st_next     = res_st_reg;
        res_slot_next   = res_slot_reg;
        res_dev_next    = res_dev_reg;
        res_blk_next    = res_blk_reg;
        pend_vld_next   = pend_vld_reg;
        pend_slot_next  = pend_slot_reg;
        pend_dev_next   = pend_dev_reg;
        pend_blk_next   = pend_blk_reg;
        push      = 1'b0;
        push_last = 1'b0;
        push_st   = ST_OK;
        push_slot = '0;
        push_dev  = '0;
        push_blk  = '0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = ent;

        refs_inc = (ent.refs == REFS_MAX) ? ent.refs : ent.refs + 16'd1;
        v = valid_reg[idx_reg];
        l = loading_reg[idx_reg];
        d = dirty_reg[idx_reg];
        match  = (ent.dev == req_dev_reg) && (ent.blk == req_blk_reg) && (v || l);
        wmatch = v && d && ((req_act_reg == ACT_FLUSH) || (req_dev_reg == 8'd0)
                 || (ent.dev == req_dev_reg));
        blocked = wmatch && pend_vld_reg && !out_free;
        vic    = free_vld_reg ? free_idx_reg : best_idx_reg;
        vic_ok = free_vld_reg || best_vld_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_act_next  = act_in;
                    req_dev_next  = device;
                    req_blk_next  = block;
                    req_err_next  = io_error;
                    res_st_next   = ST_OK;
                    res_slot_next = slot;
                    res_dev_next  = '0;
                    res_blk_next  = '0;
                    unique case (act_in)
                        ACT_GET:
                        begin
                            res_slot_next = '0;
                            if (device == 8'd0)
                            begin
                                res_st_next = ST_BAD_DEVICE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                idx_next      = '0;
                                free_vld_next = 1'b0;
                                best_vld_next = 1'b0;
                                state_next    = S_RD;
                            end
                        end
                        ACT_LOAD_DONE, ACT_PUT, ACT_MARK_DIRTY, ACT_WRITE_DONE:
                        begin
                            if ({1'b0, slot} < 7'(SLOT_COUNT))
                            begin
                                idx_next   = slot[IDX_W-1:0];
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        ACT_SYNC, ACT_FLUSH:
                        begin
                            idx_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_RD;
                        end
                        default:
                        begin
                            res_slot_next = '0;
                            state_next    = S_FIN;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                unique case (req_act_reg)
                    ACT_LOAD_DONE:
                    begin
                        loading_next[idx_reg] = 1'b0;
                        valid_next[idx_reg]   = !req_err_reg;
                        if (req_err_reg)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.refs = '0;
                        end
                        state_next = S_FIN;
                    end
                    ACT_PUT:
                    begin
                        if (ent.refs == 16'd0)
                        begin
                            res_st_next = ST_PUT_UNREF;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.refs = ent.refs - 16'd1;
                        end
                        state_next = S_FIN;
                    end
                    ACT_MARK_DIRTY:
                    begin
                        if (!d)
                        begin
                            if (dcnt_reg >= dlimit_reg)
                            begin
                                res_st_next  = ST_SYNC_NEEDED;
                                res_dev_next = ent.dev;
                            end
                            if (dcnt_reg < DIRTY_MAX)
                            begin
                                dcnt_next = dcnt_reg + 7'd1;
                            end
                            dirty_next[idx_reg] = 1'b1;
                        end
                        state_next = S_FIN;
                    end
                    ACT_WRITE_DONE:
                    begin
                        if (!req_err_reg)
                        begin
                            if (d && dcnt_reg != 7'd0)
                            begin
                                dcnt_next = dcnt_reg - 7'd1;
                            end
                            dirty_next[idx_reg] = 1'b0;
                        end
                        if (ent.refs != 16'd0)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.refs = ent.refs - 16'd1;
                        end
                        state_next = S_FIN;
                    end
                    ACT_GET:
                    begin
                        if (match)
                        begin
                            res_slot_next = 6'(idx_reg);
                            if (l)
                            begin
                                res_st_next = ST_WAIT_LOADING;
                            end
                            else
                            begin
                                res_st_next     = ST_HIT;
                                mem_we          = 1'b1;
                                mem_wdata.refs  = refs_inc;
                                mem_wdata.stamp = use_clock_reg + 64'd1;
                                use_clock_next  = use_clock_reg + 64'd1;
                                hits_next       = hits_reg + 32'd1;
                            end
                            state_next = S_FIN;
                        end
                        else
                        begin
                            if (!l && !free_vld_reg)
                            begin
                                if (!v && ent.refs == 16'd0)
                                begin
                                    free_vld_next = 1'b1;
                                    free_idx_next = idx_reg;
                                end
                                else if (ent.refs == 16'd0 && !d &&
                                         (!best_vld_reg || ent.stamp < best_stamp_reg))
                                begin
                                    best_vld_next   = 1'b1;
                                    best_idx_next   = idx_reg;
                                    best_stamp_next = ent.stamp;
                                end
                            end
                            if (idx_reg == LAST_IDX)
                            begin
                                state_next = S_VIC;
                            end
                            else
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                    end
                    default:
                    begin
                        // sync and flush: one slot per visit, stall while a request waits
                        if (!blocked)
                        begin
                            if (wmatch)
                            begin
                                if (pend_vld_reg)
                                begin
                                    push      = 1'b1;
                                    push_st   = ST_WRITE_REQ;
                                    push_slot = pend_slot_reg;
                                    push_dev  = pend_dev_reg;
                                    push_blk  = pend_blk_reg;
                                end
                                pend_vld_next  = 1'b1;
                                pend_slot_next = 6'(idx_reg);
                                pend_dev_next  = ent.dev;
                                pend_blk_next  = ent.blk;
                                mem_we         = 1'b1;
                                mem_wdata.refs = refs_inc;
                            end
                            else if (req_act_reg == ACT_FLUSH && ent.refs == 16'd0 && !l)
                            begin
                                // key cleared, use stamp kept
                                valid_next[idx_reg] = 1'b0;
                                dirty_next[idx_reg] = 1'b0;
                                mem_we              = 1'b1;
                                mem_wdata.dev       = '0;
                                mem_wdata.blk       = '0;
                            end
                            if (idx_reg == LAST_IDX)
                            begin
                                state_next = S_SEND;
                            end
                            else
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                    end
                endcase
            end
            S_VIC:
            begin
                miss_next = miss_reg + 32'd1;
                if (vic_ok)
                begin
                    if (valid_reg[vic] && dirty_reg[vic] && dcnt_reg != 7'd0)
                    begin
                        dcnt_next = dcnt_reg - 7'd1;
                    end
                    valid_next[vic]   = 1'b0;
                    loading_next[vic] = 1'b1;
                    dirty_next[vic]   = 1'b0;
                    mem_we            = 1'b1;
                    mem_waddr         = vic;
                    mem_wdata.dev     = req_dev_reg;
                    mem_wdata.blk     = req_blk_reg;
                    mem_wdata.refs    = 16'd1;
                    mem_wdata.stamp   = use_clock_reg + 64'd1;
                    use_clock_next    = use_clock_reg + 64'd1;
                    res_st_next       = ST_READ_REQ;
                    res_slot_next     = 6'(vic);
                    res_dev_next      = req_dev_reg;
                    res_blk_next      = req_blk_reg;
                end
                else
                begin
                    res_st_next = ST_NO_SLOT;
                end
                state_next = S_FIN;
            end
            S_SEND:
            begin
                if (pend_vld_reg)
                begin
                    res_st_next   = ST_WRITE_REQ;
                    res_slot_next = pend_slot_reg;
                    res_dev_next  = pend_dev_reg;
                    res_blk_next  = pend_blk_reg;
                end
                else
                begin
                    res_st_next   = (req_act_reg == ACT_SYNC) ? ST_SYNC_EMPTY : ST_OK;
                    res_slot_next = '0;
                    res_dev_next  = '0;
                    res_blk_next  = '0;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    push_st    = res_st_reg;
                    push_slot  = res_slot_reg;
                    push_dev   = res_dev_reg;
                    push_blk   = res_blk_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (mem_we)
        begin
            wflag_next[mem_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            loading_reg   <= '0;
            dirty_reg     <= '0;
            wflag_reg     <= '0;
            rd_flag_reg   <= 1'b0;
            use_clock_reg <= '0;
            dcnt_reg      <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            dlimit_reg    <= DIRTY_LIMIT_RST;
            pend_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
            best_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            loading_reg   <= loading_next;
            dirty_reg     <= dirty_next;
            wflag_reg     <= wflag_next;
            if (mem_re)
            begin
                rd_flag_reg <= wflag_reg[idx_reg];
            end
            use_clock_reg <= use_clock_next;
            dcnt_reg      <= dcnt_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            if (dirty_limit_we)
            begin
                dlimit_reg <= dirty_limit_wdata;
            end
            pend_vld_reg  <= pend_vld_next;
            free_vld_reg  <= free_vld_next;
            best_vld_reg  <= best_vld_next;
            if (push)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        req_act_reg    <= req_act_next;
        req_dev_reg    <= req_dev_next;
        req_blk_reg    <= req_blk_next;
        req_err_reg    <= req_err_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        res_st_reg     <= res_st_next;
        res_slot_reg   <= res_slot_next;
        res_dev_reg    <= res_dev_next;
        res_blk_reg    <= res_blk_next;
        pend_slot_reg  <= pend_slot_next;
        pend_dev_reg   <= pend_dev_next;
        pend_blk_reg   <= pend_blk_next;
        if (push)
        begin
            out_st_reg   <= push_st;
            out_slot_reg <= push_slot;
            out_dev_reg  <= push_dev;
            out_blk_reg  <= push_blk;
            out_last_reg <= push_last;
            out_hits_reg <= hits_reg;
            out_miss_reg <= miss_reg;
            out_dcnt_reg <= dcnt_reg;
        end
    end

    assign res_valid     = out_vld_reg;
    assign status        = out_st_reg;
    assign result_slot   = out_slot_reg;
    assign result_device = out_dev_reg;
    assign result_block  = out_blk_reg;
    assign last          = out_last_reg;
    assign hit_count     = out_hits_reg;
    assign miss_count    = out_miss_reg;
    assign dirty_total   = out_dcnt_reg;

endmodule

// File: tb/sv/tb_lru_block_buffer_cache_tags_top.sv
// Testbench for the block buffer cache tag engine: directed, dirty limit, fill/sync and random tests.
module tb_lru_block_buffer_cache_tags_top;
    import lru_bbct_pkg::*;

    localparam int NSLOT = 64;
    // Slowest request is a full slot walk plus a long receiver
    // hold-off; idle cycles in a row well beyond that mean the block has hung.
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 150;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        status_t     st;
        logic [5:0]  sl;
        logic [7:0]  dv;
        logic [31:0] bk;
        logic        lst;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [6:0]  dirty;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        dirty_limit_we;
    logic [6:0]  dirty_limit_wdata;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  action;
    logic [7:0]  device;
    logic [31:0] block;
    logic [5:0]  slot;
    logic        io_error;
    logic        res_valid;
    logic        res_ready;
    logic [3:0]  status;
    logic [5:0]  result_slot;
    logic [7:0]  result_device;
    logic [31:0] result_block;
    logic        last;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [6:0]  dirty_total;

    lru_block_buffer_cache_tags_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .dirty_limit_we    (dirty_limit_we),
        .dirty_limit_wdata (dirty_limit_wdata),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .action            (action),
        .device            (device),
        .block             (block),
        .slot              (slot),
        .io_error          (io_error),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .status            (status),
        .result_slot       (result_slot),
        .result_device     (result_device),
        .result_block      (result_block),
        .last              (last),
        .hit_count         (hit_count),
        .miss_count        (miss_count),
        .dirty_total       (dirty_total)
    );

    // 10 unit clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the cache tags, updated as each request is taken
    // ---------------------------------------------------------------
    logic        sh_valid [NSLOT];
    logic        sh_loading [NSLOT];
    logic        sh_dirty [NSLOT];
    logic [7:0]  sh_dev [NSLOT];
    logic [31:0] sh_blk [NSLOT];
    logic [15:0] sh_refs [NSLOT];
    logic [63:0] sh_stamp [NSLOT];
    logic [63:0] sh_use_clock;
    logic [6:0]  sh_dirty_cnt;
    logic [31:0] sh_hits;
    logic [31:0] sh_misses;
    logic [6:0]  sh_limit;

    cache_result_t pending_results[$];   // results still owed by the block
    cache_result_t action_batch[$];      // results of the request being modelled

    int  errors;
    bit  req_hot;       // req_valid left high after the last acceptance
    bit  calm;          // no idling on either side
    int  hold_left;     // long receiver hold-off, counted down by the receiver
    int  rx_stall;
    int  idle_cycles;

    function automatic void add_result(status_t st, logic [5:0] sl, logic [7:0] dv,
                                       logic [31:0] bk);
        cache_result_t r;
        r.st = st;
        r.sl = sl;
        r.dv = dv;
        r.bk = bk;
        r.lst = 1'b0;
        r.hits = '0;
        r.misses = '0;
        r.dirty = '0;
        action_batch.push_back(r);
    endfunction

    function automatic void refs_up(int i);
        if (sh_refs[i] != REFS_MAX)
            sh_refs[i] = sh_refs[i] + 1'b1;
    endfunction

    function automatic void dirty_down();
        if (sh_dirty_cnt != 0)
            sh_dirty_cnt = sh_dirty_cnt - 1'b1;
    endfunction

    // first free slot, else oldest clean unreferenced one; -1 if none
    function automatic int choose_victim();
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (sh_loading[i])
                continue;
            if (!sh_valid[i] && sh_refs[i] == 0)
                return i;
            if (sh_refs[i] != 0 || sh_dirty[i])
                continue;
            if (best < 0 || sh_stamp[i] < sh_stamp[best])
                best = i;
        end
        return best;
    endfunction

    // write requests for dirty valid slots, each one pinned
    function automatic void queue_writes(logic [7:0] dv);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (sh_valid[i] && sh_dirty[i] && (dv == 0 || sh_dev[i] == dv))
            begin
                refs_up(i);
                add_result(ST_WRITE_REQ, i[5:0], sh_dev[i], sh_blk[i]);
            end
        end
    endfunction

    function automatic void cache_lookup(logic [7:0] dv, logic [31:0] bk);
        int v;
        bit found;
        found = 1'b0;
        if (dv == 0)
        begin
            add_result(ST_BAD_DEVICE, '0, '0, '0);
            return;
        end
        for (int i = 0; i < NSLOT && !found; i++)
        begin
            if (sh_dev[i] != dv || sh_blk[i] != bk || !(sh_valid[i] || sh_loading[i]))
                continue;
            found = 1'b1;
            if (sh_loading[i])
                add_result(ST_WAIT_LOADING, i[5:0], '0, '0);
            else
            begin
                refs_up(i);
                sh_use_clock = sh_use_clock + 1;
                sh_stamp[i] = sh_use_clock;
                sh_hits = sh_hits + 1;
                add_result(ST_HIT, i[5:0], '0, '0);
            end
        end
        if (found)
            return;
        sh_misses = sh_misses + 1;
        v = choose_victim();
        if (v < 0)
        begin
            add_result(ST_NO_SLOT, '0, '0, '0);
            return;
        end
        if (sh_valid[v] && sh_dirty[v])
            dirty_down();
        sh_valid[v] = 1'b0;
        sh_loading[v] = 1'b1;
        sh_dev[v] = dv;
        sh_blk[v] = bk;
        sh_refs[v] = 16'd1;
        sh_dirty[v] = 1'b0;
        sh_use_clock = sh_use_clock + 1;
        sh_stamp[v] = sh_use_clock;
        add_result(ST_READ_REQ, v[5:0], dv, bk);
    endfunction

    // works out the results of one accepted request and queues them
    function automatic void predict_request(action_t act, logic [7:0] dv, logic [31:0] bk,
                                            logic [5:0] s, logic er);
        action_batch.delete();
        case (act)
            ACT_GET:
                cache_lookup(dv, bk);
            ACT_LOAD_DONE:
            begin
                sh_loading[s] = 1'b0;
                sh_valid[s] = !er;
                if (er)
                    sh_refs[s] = '0;
                add_result(ST_OK, s, '0, '0);
            end
            ACT_PUT:
            begin
                if (sh_refs[s] == 0)
                    add_result(ST_PUT_UNREF, s, '0, '0);
                else
                begin
                    sh_refs[s] = sh_refs[s] - 1'b1;
                    add_result(ST_OK, s, '0, '0);
                end
            end
            ACT_MARK_DIRTY:
            begin
                add_result(ST_OK, s, '0, '0);
                if (!sh_dirty[s])
                begin
                    // sync_needed takes the place of the plain ok
                    if (sh_dirty_cnt >= sh_limit)
                    begin
                        action_batch.delete();
                        add_result(ST_SYNC_NEEDED, s, sh_dev[s], '0);
                    end
                    if (sh_dirty_cnt != DIRTY_MAX)
                        sh_dirty_cnt = sh_dirty_cnt + 1'b1;
                    sh_dirty[s] = 1'b1;
                end
            end
            ACT_SYNC:
            begin
                queue_writes(dv);
                if (action_batch.size() == 0)
                    add_result(ST_SYNC_EMPTY, '0, '0, '0);
            end
            ACT_WRITE_DONE:
            begin
                if (!er)
                begin
                    if (sh_dirty[s])
                        dirty_down();
                    sh_dirty[s] = 1'b0;
                end
                if (sh_refs[s] != 0)
                    sh_refs[s] = sh_refs[s] - 1'b1;
                add_result(ST_OK, s, '0, '0);
            end
            ACT_FLUSH:
            begin
                queue_writes('0);
                if (action_batch.size() == 0)
                    add_result(ST_OK, '0, '0, '0);
                // pinned and loading slots survive the flush
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (sh_refs[i] != 0 || sh_loading[i])
                        continue;
                    if (sh_valid[i] && sh_dirty[i])
                        dirty_down();
                    sh_valid[i] = 1'b0;
                    sh_dirty[i] = 1'b0;
                    sh_dev[i] = '0;
                    sh_blk[i] = '0;
                end
            end
            default:
                add_result(ST_OK, '0, '0, '0);
        endcase
        foreach (action_batch[k])
        begin
            action_batch[k].lst = (k == action_batch.size() - 1);
            action_batch[k].hits = sh_hits;
            action_batch[k].misses = sh_misses;
            action_batch[k].dirty = sh_dirty_cnt;
            pending_results.push_back(action_batch[k]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_request(action_t act, logic [7:0] dv, logic [31:0] bk,
                                logic [5:0] s, logic er);
        int gap;
        // random burst of idling before the request, but never in the calm tail
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            req_valid <= 1'b0;
            req_hot = 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        action <= act;
        device <= dv;
        block <= bk;
        slot <= s;
        io_error <= er;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_request(act, dv, bk, s, er);
        req_hot = 1'b1;
    endtask

    // drop valid and wait until every owed result has come back
    task automatic drain();
        if (req_hot)
        begin
            req_valid <= 1'b0;
            req_hot = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_dirty_limit(logic [6:0] value);
        drain();
        // every request ends in a result, so only a short settle is needed
        repeat (5) @(posedge clk);
        dirty_limit_we <= 1'b1;
        dirty_limit_wdata <= value;
        @(posedge clk);
        dirty_limit_we <= 1'b0;
        sh_limit = value;
    endtask

    // ---------------------------------------------------------------
    // Result side: ready pattern and field-by-field check
    // ---------------------------------------------------------------
    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cache_result_t e;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("MISMATCH unexpected result, status %0d at %0t", status, $realtime);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status != e.st)
                    report("status", status, e.st);
                if (result_slot != e.sl)
                    report("result_slot", result_slot, e.sl);
                if (result_device != e.dv)
                    report("result_device", result_device, e.dv);
                if (result_block != e.bk)
                    report("result_block", result_block, e.bk);
                if (last != e.lst)
                    report("last", last, e.lst);
                if (hit_count != e.hits)
                    report("hit_count", hit_count, e.hits);
                if (miss_count != e.misses)
                    report("miss_count", miss_count, e.misses);
                if (dirty_total != e.dirty)
                    report("dirty_total", dirty_total, e.dirty);
            end
        end
        // next cycle's ready: long hold-off, calm, or random stall bursts
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (calm)
            res_ready <= 1'b1;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            res_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rx_stall = $urandom_range(0, 9);
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // watchdog: cycles in a row with no acceptance on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout, no traffic for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // stats, bad device, miss/wait/hit, put underflow, dirty/sync/write_done, flush
    task automatic test_directed();
        send_request(ACT_STATS, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1);
        send_request(ACT_GET, 8'h00, 32'h1234_5678, 6'h00, 1'b0);
        send_request(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 6'h00, 1'b0);
        send_request(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 6'h00, 1'b0);
        send_request(ACT_LOAD_DONE, 8'h00, 32'h0, 6'h00, 1'b0);
        send_request(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 6'h00, 1'b0);
        send_request(ACT_GET, 8'h01, 32'h0000_0000, 6'h00, 1'b0);
        send_request(ACT_PUT, 8'h00, 32'h0, 6'h00, 1'b0);
        send_request(ACT_PUT, 8'h00, 32'h0, 6'h00, 1'b0);
        send_request(ACT_PUT, 8'h00, 32'h0, 6'h00, 1'b0);
        send_request(ACT_MARK_DIRTY, 8'h00, 32'h0, 6'h00, 1'b0);
        // invalid slot still gets marked and counted
        send_request(ACT_MARK_DIRTY, 8'h00, 32'h0, 6'h3F, 1'b0);
        send_request(ACT_SYNC, 8'h07, 32'h0, 6'h00, 1'b0);
        send_request(ACT_SYNC, 8'hFF, 32'h0, 6'h00, 1'b0);
        send_request(ACT_WRITE_DONE, 8'h00, 32'h0, 6'h00, 1'b1);
        send_request(ACT_SYNC, 8'h00, 32'h0, 6'h00, 1'b0);
        send_request(ACT_WRITE_DONE, 8'h00, 32'h0, 6'h00, 1'b0);
        // no write outstanding on this one
        send_request(ACT_WRITE_DONE, 8'h00, 32'h0, 6'h2A, 1'b0);
        // load error on a loading slot drops it
        send_request(ACT_LOAD_DONE, 8'h00, 32'h0, 6'h01, 1'b1);
        send_request(ACT_FLUSH, 8'h00, 32'h0, 6'h00, 1'b0);
        send_request(ACT_FLUSH, 8'h00, 32'h0, 6'h00, 1'b0);
        // a slot emptied by the flush may now be picked as victim
        send_request(ACT_GET, 8'h80, 32'h8000_0000, 6'h00, 1'b0);
        send_request(ACT_STATS, 8'h00, 32'h0, 6'h00, 1'b0);
    endtask

    // limit at zero, mid-range and the top of its range; sync_needed follows the limit
    task automatic test_dirty_limit();
        write_dirty_limit(7'd0);
        send_request(ACT_MARK_DIRTY, 8'h00, 32'h0, 6'h10, 1'b0);
        send_request(ACT_WRITE_DONE, 8'h00, 32'h0, 6'h10, 1'b0);
        write_dirty_limit(7'd64);
        send_request(ACT_MARK_DIRTY, 8'h00, 32'h0, 6'h11, 1'b0);
        write_dirty_limit(7'd127);
        send_request(ACT_MARK_DIRTY, 8'h00, 32'h0, 6'h12, 1'b0);
    endtask

    // fill every slot, run out, load, dirty past the limit, sync under back-pressure, write_done, put
    task automatic test_fill_and_sync();
        logic [7:0] dv;
        dv = $urandom_range(1, 255);
        for (int i = 0; i < NSLOT + 1; i++)
            send_request(ACT_GET, dv, $urandom, '0, 1'b0);
        for (int i = 0; i < 8; i++)
            if (sh_loading[i])
                send_request(ACT_LOAD_DONE, '0, '0, i[5:0], $urandom_range(0, 15) == 0);
        write_dirty_limit(7'd4);
        for (int i = 0; i < 8; i++)
            send_request(ACT_MARK_DIRTY, '0, '0, i[5:0], 1'b0);
        drain();
        // receiver holds off while requests keep coming, so the block backs up
        hold_left = HOLD_CYCLES;
        send_request(ACT_SYNC, 8'h00, '0, '0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_request(ACT_WRITE_DONE, '0, '0, i[5:0], i[0]);
        for (int i = 0; i < 4; i++)
            if (sh_valid[i] && sh_refs[i] != 0)
                send_request(ACT_PUT, '0, '0, i[5:0], 1'b0);
        write_dirty_limit($urandom_range(1, 63));
    endtask

    // well-formed traffic over a few devices and blocks, with some noise
    task automatic test_random(int count);
        int pick;
        action_t act;
        logic [7:0] dv;
        logic [31:0] bk;
        logic [5:0] s;
        for (int n = 0; n < count; n++)
        begin
            if (n >= count - 20)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                act = ACT_GET;
            else if (pick < 50)
                act = ACT_LOAD_DONE;
            else if (pick < 65)
                act = ACT_PUT;
            else if (pick < 77)
                act = ACT_MARK_DIRTY;
            else if (pick < 83)
                act = ACT_SYNC;
            else if (pick < 93)
                act = ACT_WRITE_DONE;
            else if (pick < 96)
                act = ACT_FLUSH;
            else
                act = ACT_STATS;
            pick = $urandom_range(0, 9);
            dv = (pick == 0) ? 8'h00 : (pick == 1) ? 8'($urandom) : 8'($urandom_range(1, 3));
            bk = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 7));
            s = 6'($urandom);
            // mostly aim at slots that are in use
            if ($urandom_range(0, 9) < 7)
                for (int t = 0; t < 8; t++)
                begin
                    if (sh_valid[s] || sh_loading[s] || sh_refs[s] != 0)
                        break;
                    s = 6'($urandom);
                end
            send_request(act, dv, bk, s, $urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin
        errors = 0;
        req_hot = 1'b0;
        calm = 1'b0;
        hold_left = 0;
        rx_stall = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        dirty_limit_we = 1'b0;
        dirty_limit_wdata = '0;
        req_valid = 1'b0;
        action = '0;
        device = '0;
        block = '0;
        slot = '0;
        io_error = 1'b0;
        res_ready = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_loading[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_dev[i] = '0;
            sh_blk[i] = '0;
            sh_refs[i] = '0;
            sh_stamp[i] = '0;
        end
        sh_use_clock = '0;
        sh_dirty_cnt = '0;
        sh_hits = '0;
        sh_misses = '0;
        sh_limit = DIRTY_LIMIT_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_dirty_limit();
        test_fill_and_sync();
        test_random(6);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
